// ===== design/assert_macros.svh =====
// Assertion macros for the layout checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold on the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Consequent must hold on the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/flr_pkg.sv =====
`default_nettype none
package flr_pkg;
   localparam int MAX_BOXES_DEF = 64;
   localparam int SIZE_BITS_DEF = 16;
   localparam int POS_BITS      = 24;
   localparam int IDX_BITS      = 6;
   localparam int CONTAINER_RESET = 1600;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_CWIDTH  = 2'd0;
   localparam logic [1:0] CSR_CHEIGHT = 2'd1;
   localparam logic [1:0] CSR_HMODE   = 2'd2;
   localparam logic [1:0] CSR_VMODE   = 2'd3;

   // Horizontal modes
   localparam logic [2:0] HM_RTL    = 3'd1;
   localparam logic [2:0] HM_CENTER = 3'd2;
   localparam logic [2:0] HM_EVEN   = 3'd3;
   localparam logic [2:0] HM_SPREAD = 3'd4;

   // Vertical modes
   localparam logic [1:0] VM_BTT    = 2'd1;
   localparam logic [1:0] VM_MIDDLE = 2'd2;
   localparam logic [1:0] VM_SPREAD = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_Y_START,
      ST_Y_WAIT,
      ST_ROW_RD,
      ST_ROW_LD,
      ST_ROW_WAIT,
      ST_BOX_RD,
      ST_BOX_OUT
   } state_type;
endpackage
`default_nettype wire

// ===== design/flr_ram.sv =====
`default_nettype none
module flr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry into a register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== design/flow_row_layout.sv =====
// Greedy flow layout. Boxes arrive one per cycle on req_ (width and height in
// unsigned Q12.4) and are broken into rows against container_width as they
// load; the box marked final_box starts placement, during which req_ready is
// low. Placement runs the vertical spacing divide, then per row reads the row
// memory and runs the bit-serial divider for the horizontal spacing, then per
// box reads the box width memory's single read port and emits, holding on any
// rsp_ stall. One result per box comes out on rsp_, rows in layout order
// (reversed bottom-to-top), boxes in load order within a row; the last carries
// rsp_final_result. Boxes past MAX_BOXES are dropped. Configuration must be
// written through csr_ only while idle; the block itself does not enforce it.
`default_nettype none
module flow_row_layout
   import flr_pkg::*;
#(
   parameter int MAX_BOXES = MAX_BOXES_DEF,
   parameter int SIZE_BITS = SIZE_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [1:0]           csr_index,
   input  wire logic [SIZE_BITS-1:0] csr_data,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [SIZE_BITS-1:0] req_box_width,
   input  wire logic [SIZE_BITS-1:0] req_box_height,
   input  wire logic                 req_final_box,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [IDX_BITS-1:0]       rsp_box_index,
   output logic signed [POS_BITS-1:0] rsp_pos_x,
   output logic signed [POS_BITS-1:0] rsp_pos_y,
   output logic                      rsp_final_result
);
   localparam int S   = SIZE_BITS;
   localparam int IW  = $clog2(MAX_BOXES);
   localparam int CW  = IW + 1;
   localparam int TW  = S + IW;
   localparam int DVW = $clog2(MAX_BOXES + 2);
   localparam int DCW = $clog2(S + 1);
   localparam int PW  = S + IW + 3;
   localparam int XW  = (PW > POS_BITS) ? PW : POS_BITS;
   localparam int RW  = IW + CW + S + TW;

   // Configuration
   logic [S-1:0] cw_ff, ch_ff;
   logic [2:0]   hm_ff;
   logic [1:0]   vm_ff;

   // Loading state
   logic [CW-1:0] box_cnt_ff, box_cnt_in, row_cnt_ff, row_cnt_in;
   logic [TW-1:0] run_x_ff, run_x_in, prev_h_ff, prev_h_in;
   logic [S-1:0]  cur_tall_ff, cur_tall_in;
   logic [CW-1:0] cur_mem_ff, cur_mem_in;
   logic [IW-1:0] cur_first_ff, cur_first_in;

   // Placement state
   state_type state_ff, state_in;
   logic [CW-1:0] k_ff, k_in, left_ff, left_in;
   logic [IW-1:0] i_ff, i_in;
   logic signed [PW-1:0] x_ff, x_in, y_ff, y_in;
   logic [S-1:0] xs_ff, xs_in, ys_ff, ys_in, tall_ff, tall_in;
   logic pos_ff, pos_in;

   // Shared divider
   logic [DCW-1:0] div_cnt_ff, div_cnt_in;
   logic [DVW-1:0] div_rem_ff, div_rem_in, div_d_ff, div_d_in;
   logic [S-1:0]   div_quo_ff, div_quo_in;

   // Result register
   logic rsp_valid_ff, rsp_valid_in, rsp_final_ff, rsp_final_in;
   logic [IDX_BITS-1:0] rsp_idx_ff, rsp_idx_in;
   logic [POS_BITS-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   // Memories
   logic          box_we, row_we;
   logic [IW-1:0] box_wa, row_wa, row_ra;
   logic [S-1:0]  box_rd;
   logic [RW-1:0] row_wd, row_rd;

   // Control signals
   logic req_acc, slot_free;

   // Combinational helpers
   logic [TW:0]   sum_x;
   logic          new_row, load_ok;
   logic [CW-1:0] last_row;
   logic [TW-1:0] total_h, r_total;
   logic signed [TW+1:0] y_diff, x_diff;
   logic [S-1:0]  r_tall;
   logic [CW-1:0] r_mem;
   logic [IW-1:0] r_first;
   logic [DVW:0]  rem_sh;
   logic          div_ge;
   logic signed [PW-1:0] x_out, x_step;
   logic signed [XW-1:0] x_ext, y_ext;
   logic          row_done, lay_done;

   flr_ram #(.WIDTH(S), .DEPTH(MAX_BOXES)) u_box_ram (
      .clock   (clock),
      .wr_en   (box_we),
      .wr_addr (box_wa),
      .wr_data (req_box_width),
      .rd_addr (i_ff),
      .rd_data (box_rd)
   );

   flr_ram #(.WIDTH(RW), .DEPTH(MAX_BOXES)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (row_wa),
      .wr_data (row_wd),
      .rd_addr (row_ra),
      .rd_data (row_rd)
   );

   // Handshake and memory control
   always_comb begin
      csr_ready = 1'b1;
      req_ready = (state_ff == ST_IDLE);
      req_acc   = req_valid && req_ready;
      slot_free = !rsp_valid_ff || rsp_ready;
      load_ok   = box_cnt_ff < CW'(MAX_BOXES);
      box_we    = req_acc && load_ok;
      row_we    = box_we;
      box_wa    = box_cnt_ff[IW-1:0];
      last_row  = row_cnt_ff - CW'(1);
      row_ra    = (vm_ff == VM_BTT) ? IW'(last_row - k_ff) : k_ff[IW-1:0];
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_acc && req_final_box) state_in = ST_Y_START;
         ST_Y_START:  state_in = ST_Y_WAIT;
         ST_Y_WAIT:   if (div_cnt_ff == '0) state_in = ST_ROW_RD;
         ST_ROW_RD:   state_in = ST_ROW_LD;
         ST_ROW_LD:   state_in = ST_ROW_WAIT;
         ST_ROW_WAIT: if (div_cnt_ff == '0) state_in = ST_BOX_RD;
         ST_BOX_RD:   state_in = ST_BOX_OUT;
         ST_BOX_OUT: begin
            if (slot_free) begin
               if (lay_done) state_in = ST_IDLE;
               else if (row_done) state_in = ST_ROW_RD;
               else state_in = ST_BOX_RD;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath
   always_comb begin
      box_cnt_in   = box_cnt_ff;
      row_cnt_in   = row_cnt_ff;
      run_x_in     = run_x_ff;
      prev_h_in    = prev_h_ff;
      cur_tall_in  = cur_tall_ff;
      cur_mem_in   = cur_mem_ff;
      cur_first_in = cur_first_ff;
      k_in = k_ff; left_in = left_ff; i_in = i_ff;
      x_in = x_ff; y_in = y_ff;
      xs_in = xs_ff; ys_in = ys_ff; tall_in = tall_ff; pos_in = pos_ff;
      div_cnt_in = div_cnt_ff; div_rem_in = div_rem_ff;
      div_d_in = div_d_ff; div_quo_in = div_quo_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_final_in = rsp_final_ff; rsp_idx_in = rsp_idx_ff;
      rsp_x_in = rsp_x_ff; rsp_y_in = rsp_y_ff;

      sum_x   = {1'b0, run_x_ff} + (TW+1)'(req_box_width);
      new_row = (row_cnt_ff == '0) || (sum_x > (TW+1)'(cw_ff));
      row_wa  = new_row ? row_cnt_ff[IW-1:0] : last_row[IW-1:0];

      total_h = prev_h_ff + TW'(cur_tall_ff);
      y_diff  = $signed((TW+2)'(ch_ff)) - $signed((TW+2)'(total_h));
      {r_first, r_mem, r_tall, r_total} = row_rd;
      x_diff  = $signed((TW+2)'(cw_ff)) - $signed((TW+2)'(r_total));

      rem_sh  = {div_rem_ff, div_quo_ff[S-1]};
      div_ge  = rem_sh >= {1'b0, div_d_ff};

      x_out  = (hm_ff == HM_RTL) ? x_ff - PW'(box_rd) : x_ff;
      x_step = ((hm_ff == HM_EVEN) || (hm_ff == HM_SPREAD)) ? PW'(xs_ff) : '0;
      x_ext  = XW'(x_out);
      y_ext  = XW'(y_ff);
      row_done = (left_ff == CW'(1));
      lay_done = row_done && (k_ff == last_row);

      // Divide one quotient bit per cycle
      if (div_cnt_ff != '0) begin
         div_rem_in = div_ge ? DVW'(rem_sh - {1'b0, div_d_ff}) : DVW'(rem_sh);
         div_quo_in = {div_quo_ff[S-2:0], div_ge};
         div_cnt_in = div_cnt_ff - DCW'(1);
      end

      // Load a box into the current or a new row
      if (box_we) begin
         if (new_row) begin
            row_cnt_in   = row_cnt_ff + CW'(1);
            prev_h_in    = prev_h_ff + TW'(cur_tall_ff);
            run_x_in     = TW'(req_box_width);
            cur_tall_in  = req_box_height;
            cur_mem_in   = CW'(1);
            cur_first_in = box_cnt_ff[IW-1:0];
         end else begin
            run_x_in    = sum_x[TW-1:0];
            cur_tall_in = (req_box_height > cur_tall_ff) ? req_box_height : cur_tall_ff;
            cur_mem_in  = cur_mem_ff + CW'(1);
         end
         box_cnt_in = box_cnt_ff + CW'(1);
      end
      row_wd = {cur_first_in, cur_mem_in, cur_tall_in, run_x_in};

      case (state_ff)
         // Start the vertical spacing divide
         ST_Y_START: begin
            pos_in     = !y_diff[TW+1] && (y_diff != '0);
            div_quo_in = y_diff[S-1:0];
            div_rem_in = '0;
            div_cnt_in = DCW'(S);
            if (vm_ff == VM_SPREAD && row_cnt_ff > CW'(1)) div_d_in = DVW'(last_row);
            else if (vm_ff == VM_SPREAD) div_d_in = DVW'(1);
            else div_d_in = DVW'(2);
         end
         // Take vertical spacing, set the first row's y
         ST_Y_WAIT: begin
            if (div_cnt_ff == '0) begin
               ys_in = (pos_ff && (vm_ff == VM_MIDDLE || vm_ff == VM_SPREAD))
                       ? div_quo_ff : '0;
               if (vm_ff == VM_BTT) y_in = PW'(ch_ff);
               else if (vm_ff == VM_MIDDLE) y_in = PW'(ys_in);
               else y_in = '0;
               k_in = '0;
            end
         end
         // Latch the row and start the horizontal spacing divide
         ST_ROW_LD: begin
            tall_in    = r_tall;
            left_in    = r_mem;
            i_in       = r_first;
            pos_in     = !x_diff[TW+1] && (x_diff != '0);
            div_quo_in = x_diff[S-1:0];
            div_rem_in = '0;
            div_cnt_in = DCW'(S);
            if (hm_ff == HM_EVEN) div_d_in = DVW'(r_mem + CW'(1));
            else if (hm_ff == HM_SPREAD && r_mem > CW'(1)) div_d_in = DVW'(r_mem - CW'(1));
            else if (hm_ff == HM_CENTER) div_d_in = DVW'(2);
            else div_d_in = DVW'(1);
         end
         // Set the row's starting x and, bottom-to-top, move y up
         ST_ROW_WAIT: begin
            if (div_cnt_ff == '0) begin
               xs_in = (pos_ff && (hm_ff == HM_CENTER || hm_ff == HM_EVEN ||
                        hm_ff == HM_SPREAD)) ? div_quo_ff : '0;
               if (hm_ff == HM_CENTER || hm_ff == HM_EVEN) x_in = PW'(xs_in);
               else if (hm_ff == HM_RTL) x_in = PW'(cw_ff);
               else x_in = '0;
               if (vm_ff == VM_BTT) y_in = y_ff - PW'(tall_ff);
            end
         end
         // Emit one box and advance
         ST_BOX_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_final_in = lay_done;
               rsp_idx_in   = IDX_BITS'(i_ff);
               rsp_x_in     = x_ext[POS_BITS-1:0];
               rsp_y_in     = y_ext[POS_BITS-1:0];
               x_in = (hm_ff == HM_RTL) ? x_out : x_ff + PW'(box_rd) + x_step;
               i_in    = i_ff + IW'(1);
               left_in = left_ff - CW'(1);
               if (row_done) begin
                  k_in = k_ff + CW'(1);
                  if (vm_ff != VM_BTT) begin
                     y_in = y_ff + PW'(tall_ff) +
                            ((vm_ff == VM_SPREAD) ? PW'(ys_ff) : PW'(0));
                  end
               end
               if (lay_done) begin
                  box_cnt_in  = '0;
                  row_cnt_in  = '0;
                  run_x_in    = '0;
                  prev_h_in   = '0;
                  cur_tall_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cw_ff        <= S'(CONTAINER_RESET);
         ch_ff        <= S'(CONTAINER_RESET);
         hm_ff        <= '0;
         vm_ff        <= '0;
         state_ff     <= ST_IDLE;
         box_cnt_ff   <= '0;
         row_cnt_ff   <= '0;
         run_x_ff     <= '0;
         prev_h_ff    <= '0;
         cur_tall_ff  <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CWIDTH:  cw_ff <= csr_data;
               CSR_CHEIGHT: ch_ff <= csr_data;
               CSR_HMODE:   hm_ff <= csr_data[2:0];
               CSR_VMODE:   vm_ff <= csr_data[1:0];
               default: begin
               end
            endcase
         end
         state_ff     <= state_in;
         box_cnt_ff   <= box_cnt_in;
         row_cnt_ff   <= row_cnt_in;
         run_x_ff     <= run_x_in;
         prev_h_ff    <= prev_h_in;
         cur_tall_ff  <= cur_tall_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_mem_ff   <= cur_mem_in;
      cur_first_ff <= cur_first_in;
      k_ff <= k_in; left_ff <= left_in; i_ff <= i_in;
      x_ff <= x_in; y_ff <= y_in;
      xs_ff <= xs_in; ys_ff <= ys_in; tall_ff <= tall_in; pos_ff <= pos_in;
      div_rem_ff <= div_rem_in; div_d_ff <= div_d_in; div_quo_ff <= div_quo_in;
      rsp_final_ff <= rsp_final_in; rsp_idx_ff <= rsp_idx_in;
      rsp_x_ff <= rsp_x_in; rsp_y_ff <= rsp_y_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_box_index    = rsp_idx_ff;
   assign rsp_pos_x        = rsp_x_ff;
   assign rsp_pos_y        = rsp_y_ff;
   assign rsp_final_result = rsp_final_ff;
endmodule
`default_nettype wire

// ===== design/flr_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module flr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_final_box,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [23:0] rsp_pos_x,
   input wire logic [23:0] rsp_pos_y,
   input wire logic        rsp_final_result
);
   // After a plain box is accepted, the block takes the next item on the next cycle
   `ASSERT_NEXT(a_load_one_cycle, clock, reset, req_valid && req_ready && !req_final_box, req_ready)
   // The final box starts placement and closes the input
   `ASSERT_NEXT(a_final_busy, clock, reset, req_valid && req_ready && req_final_box, !req_ready)
   // No new result is shown while the input is open
   `ASSERT_NEXT(a_no_new_rsp, clock, reset, req_ready && (!rsp_valid || rsp_ready), !rsp_valid)
   // A stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y) && $stable(rsp_final_result))
endmodule

bind flow_row_layout flr_checker u_flr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_final_box    (req_final_box),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_pos_x        (rsp_pos_x),
   .rsp_pos_y        (rsp_pos_y),
   .rsp_final_result (rsp_final_result)
);
`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none
module tb_top;
   import flr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] HM_LEFT  = 3'd0;
   localparam logic [1:0] VM_TOP   = 2'd0;
   localparam int BOX_SLOTS        = MAX_BOXES_DEF;
   localparam int STALL_LIMIT      = 20000;
   localparam int DRAIN_CYCLES     = 60;
   localparam int SEGMENTS         = 12;

   typedef struct packed {
      logic [15:0] width;
      logic [15:0] height;
      logic        last;
   } box_item_type;

   typedef struct packed {
      logic [IDX_BITS-1:0] index;
      logic [POS_BITS-1:0] x;
      logic [POS_BITS-1:0] y;
      logic                last;
   } placement_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic [1:0] csr_index = CSR_CWIDTH;
   logic [15:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic [15:0] req_box_width = '0;
   logic [15:0] req_box_height = '0;
   logic req_final_box = 1'b0;
   logic rsp_ready = 1'b0;
   wire logic csr_ready, req_ready, rsp_valid, rsp_final_result;
   wire logic [IDX_BITS-1:0] rsp_box_index;
   wire logic signed [POS_BITS-1:0] rsp_pos_x, rsp_pos_y;

   flow_row_layout dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_box_width(req_box_width), .req_box_height(req_box_height),
      .req_final_box(req_final_box),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_box_index(rsp_box_index), .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y), .rsp_final_result(rsp_final_result)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // layout shadow state
   logic [15:0] cfg_width = 16'(CONTAINER_RESET);
   logic [15:0] cfg_height = 16'(CONTAINER_RESET);
   logic [2:0]  cfg_hmode = HM_LEFT;
   logic [1:0]  cfg_vmode = VM_TOP;
   logic [15:0] stored_w [BOX_SLOTS];
   logic [15:0] stored_h [BOX_SLOTS];
   int          stored_row [BOX_SLOTS];
   longint      row_width [BOX_SLOTS];
   longint      row_height [BOX_SLOTS];
   int          row_size [BOX_SLOTS];
   int          boxes_held = 0;
   int          rows_held = 0;
   longint      line_x = 0;

   box_item_type  pending_boxes[$];
   placement_type expected_places[$];
   box_item_type  cur_box;
   int          boxes_sent = 0;
   int          errors = 0;
   int          send_idle = 16;
   int          recv_idle = 73;
   int          hold_left = 0;
   bit          hold_done = 0;
   int          quiet_cycles = 0;

   // break the box into the current row or open a new one
   task automatic load_box(input logic [15:0] w, input logic [15:0] h);
      int r;
      if (boxes_held >= BOX_SLOTS) return;
      if (rows_held == 0 ||
          (row_size[rows_held-1] != 0 && line_x + w > cfg_width)) begin
         r = rows_held;
         row_width[r] = 0;
         row_height[r] = 0;
         row_size[r] = 0;
         rows_held++;
      end else begin
         r = rows_held - 1;
      end
      row_width[r] += w;
      if (h > row_height[r]) row_height[r] = h;
      row_size[r]++;
      stored_w[boxes_held] = w;
      stored_h[boxes_held] = h;
      stored_row[boxes_held] = r;
      boxes_held++;
      line_x = row_width[r];
   endtask

   // compute every box position of the finished list
   task automatic place_boxes();
      longint cw, ch, total_h, y_diff, y_space, y, x_diff, x_space, x;
      int r, n;
      placement_type p;
      cw = cfg_width;
      ch = cfg_height;
      total_h = 0;
      y_space = 0;
      y = 0;
      n = 0;
      for (int k = 0; k < rows_held; k++) total_h += row_height[k];
      if (cfg_vmode == VM_BTT) y = ch;
      y_diff = ch - total_h;
      if (y_diff > 0) begin
         if (cfg_vmode == VM_MIDDLE) begin
            y_space = y_diff / 2;
            y += y_space;
         end else if (cfg_vmode == VM_SPREAD) begin
            y_space = y_diff / ((rows_held > 1) ? rows_held - 1 : 1);
         end
      end
      for (int k = 0; k < rows_held; k++) begin
         r = (cfg_vmode == VM_BTT) ? rows_held - 1 - k : k;
         x_diff = cw - row_width[r];
         x_space = 0;
         x = 0;
         if (x_diff > 0) begin
            if (cfg_hmode == HM_CENTER) x_space = x_diff / 2;
            else if (cfg_hmode == HM_EVEN) x_space = x_diff / (row_size[r] + 1);
            else if (cfg_hmode == HM_SPREAD)
               x_space = x_diff / ((row_size[r] > 1) ? row_size[r] - 1 : 1);
         end
         if (cfg_hmode == HM_CENTER || cfg_hmode == HM_EVEN) x += x_space;
         else if (cfg_hmode == HM_RTL) x = cw;
         if (cfg_vmode == VM_BTT) y -= row_height[r];
         for (int i = 0; i < boxes_held; i++) begin
            if (stored_row[i] == r) begin
               if (cfg_hmode == HM_RTL) x -= stored_w[i];
               p.index = IDX_BITS'(i);
               p.x = POS_BITS'(x);
               p.y = POS_BITS'(y);
               p.last = 1'b0;
               expected_places.push_back(p);
               n++;
               if (cfg_hmode != HM_RTL) x += stored_w[i];
               if (cfg_hmode == HM_EVEN || cfg_hmode == HM_SPREAD) x += x_space;
            end
         end
         if (cfg_vmode != VM_BTT) y += row_height[r];
         if (cfg_vmode == VM_SPREAD) y += y_space;
      end
      if (n > 0) expected_places[$].last = 1'b1;
      boxes_held = 0;
      rows_held = 0;
      line_x = 0;
   endtask

   // driver: hold each item until accepted, then advance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            boxes_sent++;
            load_box(cur_box.width, cur_box.height);
            if (cur_box.last) place_boxes();
         end
         if (!req_valid || req_ready) begin
            if (pending_boxes.size() != 0 && $urandom_range(99) >= send_idle) begin
               cur_box = pending_boxes.pop_front();
               req_valid <= 1'b1;
               req_box_width <= cur_box.width;
               req_box_height <= cur_box.height;
               req_final_box <= cur_box.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each placed item, then pick the next ready
   always @(posedge clock) begin
      placement_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_places.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected item: index %0d x %0d y %0d last %0b",
                           rsp_box_index, rsp_pos_x, rsp_pos_y, rsp_final_result);
            end else begin
               want = expected_places.pop_front();
               if (rsp_box_index !== want.index || rsp_pos_x !== want.x ||
                   rsp_pos_y !== want.y || rsp_final_result !== want.last) begin
                  errors++;
                  if (errors <= 10)
                     $display({"mismatch: expected index %0d x %0d y %0d last %0b,",
                               " got index %0d x %0d y %0d last %0b"},
                              want.index, $signed(want.x), $signed(want.y), want.last,
                              rsp_box_index, rsp_pos_x, rsp_pos_y, rsp_final_result);
               end
            end
         end
         // long hold-off once, so the block fills and stalls its input
         if (!hold_done && boxes_sent >= 20) begin
            hold_done <= 1'b1;
            hold_left <= 600;
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   // watchdog on accepted items
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_CWIDTH:  cfg_width = value;
         CSR_CHEIGHT: cfg_height = value;
         CSR_HMODE:   cfg_hmode = value[2:0];
         default:     cfg_vmode = value[1:0];
      endcase
   endtask

   task automatic add_box(input logic [15:0] w, input logic [15:0] h, input logic last);
      box_item_type b;
      b.width = w;
      b.height = h;
      b.last = last;
      pending_boxes.push_back(b);
   endtask

   function automatic logic [15:0] rand_size();
      return ($urandom_range(99) < 25) ? 16'($urandom) : 16'($urandom_range(0, 900));
   endfunction

   task automatic drain();
      while (pending_boxes.size() != 0 || req_valid || expected_places.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int len, added;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int s = 0; s < SEGMENTS; s++) begin
         @(negedge clock);
         if (s < 4) begin
            send_idle = 16; recv_idle = 73;
         end else if (s < 8) begin
            send_idle = 73; recv_idle = 16;
         end else begin
            send_idle = 0; recv_idle = 0;
         end
         write_reg(CSR_CWIDTH, (s == 1) ? 16'd0 : (s == 2) ? 16'hFFFF :
                   (s == 0) ? 16'(CONTAINER_RESET) : 16'($urandom_range(400, 3000)));
         write_reg(CSR_CHEIGHT, (s == 3) ? 16'd0 : (s == 4) ? 16'hFFFF :
                   16'($urandom_range(400, 4000)));
         write_reg(CSR_HMODE, 16'(s % 8));
         write_reg(CSR_VMODE, 16'(s % 4));
         if (s == 0) begin
            // extremes, an exact fit, and an oversized box opening a row
            add_box(16'd0, 16'd0, 1'b1);
            add_box(16'hFFFF, 16'hFFFF, 1'b1);
            add_box(16'd800, 16'd100, 1'b0);
            add_box(16'd800, 16'd200, 1'b0);
            add_box(16'd1, 16'd50, 1'b0);
            add_box(16'd5000, 16'd10, 1'b0);
            add_box(16'd300, 16'hFFFF, 1'b1);
         end
         if (s == 5) begin
            // overfull list: boxes past the store size are dropped
            for (int i = 0; i < BOX_SLOTS + 2; i++)
               add_box(16'($urandom_range(0, 600)), 16'($urandom_range(0, 300)),
                       i == BOX_SLOTS + 1);
         end
         added = 0;
         while (added < 2) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
               add_box(rand_size(), rand_size(), i == len - 1);
            added += len;
         end
         drain();
      end
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
`default_nettype wire

// ===== flow_row_layout.f =====
+incdir+design
design/flr_pkg.sv
design/flr_ram.sv
design/flow_row_layout.sv
design/flr_checker.sv
dv/tb_top.sv
